// ----- hdl/mfhb_pkg.sv -----
// Shared types and constants of the MAC frame header builder.
package mfhb_pkg;

   // Request kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DATA  = 1'b1;

   // Frame types
   localparam logic [1:0] FTYPE_INVALID = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RADIO_OFF = 3'd1;
   localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_NO_FRAME  = 3'd4;

   // Configuration register indexes
   localparam logic [1:0] CSR_RADIO_ON   = 2'd0;
   localparam logic [1:0] CSR_OWN_PAN    = 2'd1;
   localparam logic [1:0] CSR_OWN_SHORT  = 2'd2;
   localparam logic [1:0] CSR_OWN_LONG   = 2'd3;

   // Frame control bits and values
   localparam logic [7:0] FC0_ACK_REQ  = 8'h20;
   localparam logic [7:0] FC0_PAN_COMP = 8'h40;
   localparam logic [7:0] FC1_LONG     = 8'hcc;
   localparam logic [7:0] FC1_SHORT    = 8'h88;

   // Header bytes after the length byte, per addressing mode
   localparam int HDR_BYTES_MAX = 19;
   localparam logic [4:0] HDR_LEN_LONG       = 5'd19;
   localparam logic [4:0] HDR_LEN_SHORT      = 5'd11;
   localparam logic [4:0] HDR_LEN_SHORT_COMP = 5'd9;
   localparam logic [8:0] FCS_LEN            = 9'd2;

   localparam int HDR_BITS = 8 * HDR_BYTES_MAX;

   typedef logic [1:0] csr_index_type;
   typedef logic [4:0] hdr_count_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  frame_type;
      logic        long_mode;
      logic        ack_request;
      logic [15:0] dest_pan;
      logic [15:0] dest_short;
      logic [63:0] dest_long;
      logic [7:0]  body_len;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       has_byte;
      logic [2:0] status;
      logic       last;
   } rsp_type;

   // Load command for the header shifter
   typedef struct packed {
      logic                  load;
      hdr_count_type         count;
      logic [HDR_BITS-1:0]   data;
   } hdr_load_type;

   // Status of the header shifter
   typedef struct packed {
      logic       busy;
      logic       last;
      logic [7:0] head_byte;
   } hdr_stat_type;

endpackage

// ----- hdl/mfhb_if.sv -----
// Request and response channel interfaces of the MAC frame header builder.
interface mfhb_req_if;
   logic             valid;
   logic             ready;
   mfhb_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mfhb_rsp_if;
   logic             valid;
   logic             ready;
   mfhb_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/mfhb_hdr_shifter.sv -----
// Byte-serial shift register that streams the header bytes after the length byte.
module mfhb_hdr_shifter (
   input  logic                   clock,
   input  logic                   reset,
   input  mfhb_pkg::hdr_load_type load_cmd,
   input  logic                   advance,
   output mfhb_pkg::hdr_stat_type stat
);
   import mfhb_pkg::*;

   logic [HDR_BITS-1:0] shift_ff, shift_in;
   hdr_count_type       count_ff, count_in;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (load_cmd.load) begin
         shift_in = load_cmd.data;
         count_in = load_cmd.count;
      end else if (advance) begin
         // drop the byte just sent, move the next one to the head
         shift_in = {8'd0, shift_ff[HDR_BITS-1:8]};
         count_in = count_ff - 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign stat.busy      = (count_ff != '0);
   assign stat.last      = (count_ff == 5'd1);
   assign stat.head_byte = shift_ff[7:0];

endmodule

// ----- hdl/mac_frame_header_builder_unit.sv -----
// Top level of the MAC frame header builder: request decode, state and response register.
// The first response byte is registered and valid in the cycle after its request is accepted.
// A payload request gives one response byte; a header request gives 10, 12 or 20 bytes,
//   one per header byte, via the byte-wide header shift register, which holds off requests.
// Error requests (radio off, bad type, too long, no frame open) give one status response.
// Synchronous active-high reset clears sequence number, open frame and radio_on;
//   all address registers reset to zero.
module mac_frame_header_builder_unit #(
   parameter int MAX_FRAME_LEN = 127
) (
   input  logic                    clock,
   input  logic                    reset,
   mfhb_req_if.sink                req_ch,
   mfhb_rsp_if.source              rsp_ch,
   input  logic                    csr_we,
   input  mfhb_pkg::csr_index_type csr_index,
   input  logic [63:0]             csr_wdata
);
   import mfhb_pkg::*;

   // Configuration registers
   logic        radio_on_ff;
   logic [15:0] own_pan_ff;
   logic [15:0] own_short_ff;
   logic [63:0] own_long_ff;

   // Frame state
   logic [7:0] seq_ff, seq_in;
   logic       ack_wait_ff, ack_wait_in;
   logic [7:0] bytes_left_ff, bytes_left_in;

   // Response register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   hdr_load_type load_cmd;
   hdr_stat_type hdr_stat;
   logic         slot_free;
   logic         accept;
   logic         advance;

   // Header decode
   req_type     rq;
   logic        pan_comp;
   logic [7:0]  fc0;
   logic [7:0]  fc1;
   logic [4:0]  hdr_len;
   logic [8:0]  phr;
   logic        too_long;
   logic        hdr_start;
   logic [HDR_BITS-1:0] hdr_data;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         radio_on_ff  <= 1'b0;
         own_pan_ff   <= '0;
         own_short_ff <= '0;
         own_long_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RADIO_ON:  radio_on_ff  <= csr_wdata[0];
            CSR_OWN_PAN:   own_pan_ff   <= csr_wdata[15:0];
            CSR_OWN_SHORT: own_short_ff <= csr_wdata[15:0];
            CSR_OWN_LONG:  own_long_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The response slot frees when empty or when its byte is taken this cycle.
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !hdr_stat.busy && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;
   assign advance      = hdr_stat.busy && slot_free;
   assign rq           = req_ch.payload;

   // Assemble frame control and the header bytes after the length byte,
   // least significant byte first at the shifter head.
   always_comb begin
      pan_comp = !rq.long_mode && (rq.dest_pan == own_pan_ff);
      fc0 = {6'd0, rq.frame_type}
          | (rq.ack_request ? FC0_ACK_REQ : 8'd0)
          | (pan_comp ? FC0_PAN_COMP : 8'd0);
      fc1 = rq.long_mode ? FC1_LONG : FC1_SHORT;
      if (rq.long_mode) begin
         hdr_len  = HDR_LEN_LONG;
         hdr_data = {own_long_ff, rq.dest_long, seq_ff, fc1, fc0};
      end else if (pan_comp) begin
         hdr_len  = HDR_LEN_SHORT_COMP;
         hdr_data = {80'd0, own_short_ff, rq.dest_short, rq.dest_pan, seq_ff, fc1, fc0};
      end else begin
         hdr_len  = HDR_LEN_SHORT;
         hdr_data = {64'd0, own_short_ff, own_pan_ff, rq.dest_short, rq.dest_pan,
                     seq_ff, fc1, fc0};
      end
      phr      = {1'b0, rq.body_len} + {4'd0, hdr_len} + FCS_LEN;
      too_long = phr > 9'(MAX_FRAME_LEN);
      hdr_start = accept && (rq.kind == KIND_START) && radio_on_ff
                  && (rq.frame_type != FTYPE_INVALID);
   end

   // Request decode, frame state and response register next values
   always_comb begin
      seq_in        = seq_ff;
      ack_wait_in   = ack_wait_ff;
      bytes_left_in = bytes_left_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      // every header byte after the length byte goes through the shifter
      load_cmd      = '{load: 1'b0, count: hdr_len, data: hdr_data};

      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{frame_byte: 8'd0, has_byte: 1'b0, status: ST_OK, last: 1'b1};
         if (rq.kind == KIND_DATA) begin
            if (bytes_left_ff == 8'd0) begin
               rsp_data_in.status = ST_NO_FRAME;
            end else begin
               bytes_left_in          = bytes_left_ff - 8'd1;
               rsp_data_in.frame_byte = rq.data_byte;
               rsp_data_in.has_byte   = 1'b1;
            end
         end else begin
            // a new start abandons any open frame
            bytes_left_in = 8'd0;
            if (!radio_on_ff) begin
               rsp_data_in.status = ST_RADIO_OFF;
            end else if (rq.frame_type == FTYPE_INVALID) begin
               rsp_data_in.status = ST_BAD_TYPE;
            end else begin
               // sequence number advances even when the frame is refused as too long
               ack_wait_in = rq.ack_request;
               seq_in      = seq_ff + 8'd1;
               if (too_long) begin
                  rsp_data_in.status = ST_TOO_LONG;
               end else begin
                  bytes_left_in          = rq.body_len;
                  rsp_data_in.frame_byte = phr[7:0];
                  rsp_data_in.has_byte   = 1'b1;
                  rsp_data_in.last       = 1'b0;
                  load_cmd.load          = 1'b1;
               end
            end
         end
      end else if (advance) begin
         // move the next header byte into the response slot
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{frame_byte: hdr_stat.head_byte, has_byte: 1'b1,
                          status: ST_OK, last: hdr_stat.last};
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         seq_ff        <= '0;
         ack_wait_ff   <= 1'b0;
         bytes_left_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seq_ff        <= seq_in;
         ack_wait_ff   <= ack_wait_in;
         bytes_left_ff <= bytes_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   mfhb_hdr_shifter u_hdr_shifter (
      .clock    (clock),
      .reset    (reset),
      .load_cmd (load_cmd),
      .advance  (advance),
      .stat     (hdr_stat)
   );

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

   // Hold off new requests while header bytes are still streaming.
   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      hdr_stat.busy |-> !req_ch.ready)
      else $error("request accepted while header streaming");

   // A response without a byte is always a single final error result.
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.has_byte) |->
         (rsp_data_ff.last && rsp_data_ff.status != ST_OK && rsp_data_ff.frame_byte == 8'd0))
      else $error("malformed status response");

   // Advance the sequence number and latch ack request on every accepted-type start.
   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      hdr_start |=> (seq_ff == $past(seq_ff) + 8'd1)
                    && (ack_wait_ff == $past(req_ch.payload.ack_request)))
      else $error("sequence or ack state not updated on start");

   // A loaded header always leaves its first byte unfinished in the response slot.
   a_load_first: assert property (@(posedge clock) disable iff (reset)
      load_cmd.load |=> (rsp_valid_ff && !rsp_data_ff.last && hdr_stat.busy))
      else $error("header load did not start streaming");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench of the MAC frame header builder: directed and random requests checked by a predictor.
module tb;
   import mfhb_pkg::*;

   localparam int FRAME_LIMIT    = 127;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int PHASE_ITEMS    = 100;
   localparam int SETTLE_CYCLES  = 30;

   localparam logic [1:0] FTYPE_BEACON = 2'd0;
   localparam logic [1:0] FTYPE_DATA   = 2'd1;
   localparam logic [1:0] FTYPE_ACK    = 2'd2;

   // Drive every block input from a variable with a known value at time zero.
   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   req_type       req_payload = '0;
   logic          rsp_ready   = 1'b0;
   logic          csr_we      = 1'b0;
   csr_index_type csr_index   = CSR_RADIO_ON;
   logic [63:0]   csr_wdata   = '0;

   mfhb_req_if req_ch ();
   mfhb_rsp_if rsp_ch ();

   assign req_ch.valid   = req_valid;
   assign req_ch.payload = req_payload;
   assign rsp_ch.ready   = rsp_ready;

   mac_frame_header_builder_unit #(
      .MAX_FRAME_LEN (FRAME_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copies of the registers and of the frame state, all zero after reset.
   logic        radio_on_m  = 1'b0;
   logic [15:0] own_pan_m   = '0;
   logic [15:0] own_short_m = '0;
   logic [63:0] own_long_m  = '0;
   logic [7:0]  next_seq    = '0;
   logic [7:0]  open_bytes  = '0;

   req_type feed_q[$];      // requests waiting for the driver
   rsp_type frame_rsp_q[$]; // frame bytes and status words still to come

   int   send_idle_pct = 16;
   int   recv_idle_pct = 87;
   int   holdoff_asked = 0;
   int   holdoff_done  = 0;
   int   holdoff_left  = 0;
   int   mismatches    = 0;
   int   cycle_count   = 0;
   int   phase_items   = 0;
   logic req_taken     = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Work out the responses of one accepted request and advance the shadow state.
   task automatic predict_frame(input req_type r);
      logic [7:0] hdr[$];
      logic       comp;
      int         phr;
      if (r.kind == KIND_DATA) begin
         // Payload bytes pass whatever the radio state; with no frame open give a status.
         if (open_bytes == 0) begin
            frame_rsp_q.push_back({8'h00, 1'b0, ST_NO_FRAME, 1'b1});
         end else begin
            open_bytes = open_bytes - 8'd1;
            frame_rsp_q.push_back({r.data_byte, 1'b1, ST_OK, 1'b1});
         end
         return;
      end
      // Any start drops the frame that is open.
      open_bytes = '0;
      if (!radio_on_m) begin
         frame_rsp_q.push_back({8'h00, 1'b0, ST_RADIO_OFF, 1'b1});
         return;
      end
      if (r.frame_type == FTYPE_INVALID) begin
         frame_rsp_q.push_back({8'h00, 1'b0, ST_BAD_TYPE, 1'b1});
         return;
      end
      comp = !r.long_mode && (r.dest_pan == own_pan_m);
      hdr.push_back({6'd0, r.frame_type} | (r.ack_request ? FC0_ACK_REQ : 8'h00)
                    | (comp ? FC0_PAN_COMP : 8'h00));
      hdr.push_back(r.long_mode ? FC1_LONG : FC1_SHORT);
      hdr.push_back(next_seq);
      // The sequence number advances even when the frame turns out too long.
      next_seq = next_seq + 8'd1;
      if (r.long_mode) begin
         for (int i = 0; i < 8; i++) hdr.push_back(r.dest_long[8*i +: 8]);
         for (int i = 0; i < 8; i++) hdr.push_back(own_long_m[8*i +: 8]);
      end else begin
         hdr.push_back(r.dest_pan[7:0]);
         hdr.push_back(r.dest_pan[15:8]);
         hdr.push_back(r.dest_short[7:0]);
         hdr.push_back(r.dest_short[15:8]);
         if (!comp) begin
            hdr.push_back(own_pan_m[7:0]);
            hdr.push_back(own_pan_m[15:8]);
         end
         hdr.push_back(own_short_m[7:0]);
         hdr.push_back(own_short_m[15:8]);
      end
      // Length byte: header after it, payload and the two FCS bytes.
      phr = hdr.size() + int'(r.body_len) + 2;
      if (phr > FRAME_LIMIT) begin
         frame_rsp_q.push_back({8'h00, 1'b0, ST_TOO_LONG, 1'b1});
         return;
      end
      hdr.push_front(8'(phr));
      foreach (hdr[i]) frame_rsp_q.push_back({hdr[i], 1'b1, ST_OK, i == hdr.size() - 1});
      open_bytes = r.body_len;
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Sample both channels at the rising edge: check a response first, then predict a request.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_taken <= req_ch.valid && req_ch.ready;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (frame_rsp_q.size() == 0) begin
            $error("response with none awaited: frame_byte %0h status %0d",
                   got.frame_byte, got.status);
            mismatches++;
         end else begin
            want = frame_rsp_q.pop_front();
            check_field("frame_byte", want.frame_byte, got.frame_byte);
            check_field("has_byte", 8'(want.has_byte), 8'(got.has_byte));
            check_field("status", 8'(want.status), 8'(got.status));
            check_field("last", 8'(want.last), 8'(got.last));
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) predict_frame(req_ch.payload);
   end

   // Request driver: hold a request until taken, then offer the next one or idle.
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= feed_q.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus a long hold-off whenever one is asked for.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_done != holdoff_asked) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= holdoff_done + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic req_type random_req();
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom});
      return r;
   endfunction

   task automatic offer(input req_type r);
      feed_q.push_back(r);
      phase_items++;
   endtask

   task automatic offer_start(input logic [1:0] ftype, input logic lmode, input logic ack,
                              input logic [15:0] dpan, input logic [15:0] dshort,
                              input logic [63:0] dlong, input logic [7:0] plen);
      req_type r;
      r = random_req();
      r.kind        = KIND_START;
      r.frame_type  = ftype;
      r.long_mode   = lmode;
      r.ack_request = ack;
      r.dest_pan    = dpan;
      r.dest_short  = dshort;
      r.dest_long   = dlong;
      r.body_len    = plen;
      offer(r);
   endtask

   task automatic offer_data(input logic [7:0] b);
      req_type r;
      r = random_req();
      r.kind      = KIND_DATA;
      r.data_byte = b;
      offer(r);
   endtask

   // Mostly well-formed frames with random content; some truncated, too long or noisy.
   task automatic offer_random_frame();
      logic [7:0] plen;
      int         roll;
      int         sent;
      roll = $urandom_range(99);
      if (roll < 30) plen = 8'd0;
      else if (roll < 70) plen = 8'($urandom_range(6, 1));
      else if (roll < 85) plen = 8'($urandom_range(40, 7));
      else plen = 8'($urandom_range(255, 100));
      // Cut long payloads short so that big lengths do not swamp the item count.
      sent = (plen > 40) ? $urandom_range(4) : int'(plen);
      if ($urandom_range(99) < 15) sent = $urandom_range(sent);
      if ($urandom_range(99) < 8) begin
         offer_start(FTYPE_INVALID, 1'($urandom), 1'($urandom), 16'($urandom),
                     16'($urandom), {$urandom, $urandom}, 8'($urandom));
      end
      offer_start(2'($urandom_range(2)), 1'($urandom), 1'($urandom),
                  $urandom_range(1) ? own_pan_m : 16'($urandom), 16'($urandom),
                  {$urandom, $urandom}, plen);
      repeat (sent) offer_data(8'($urandom));
      if ($urandom_range(99) < 10) offer_data(8'($urandom));
   endtask

   // Hold until every request went in and every response came out, then pause briefly.
   task automatic wait_idle();
      do @(negedge clock);
      while (feed_q.size() != 0 || req_valid || frame_rsp_q.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RADIO_ON:  radio_on_m  = val[0];
         CSR_OWN_PAN:   own_pan_m   = val[15:0];
         CSR_OWN_SHORT: own_short_m = val[15:0];
         CSR_OWN_LONG:  own_long_m  = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic radio, input logic [15:0] pan,
                             input logic [15:0] short_addr, input logic [63:0] ext_addr);
      write_reg(CSR_RADIO_ON, {63'd0, radio});
      write_reg(CSR_OWN_PAN, {48'd0, pan});
      write_reg(CSR_OWN_SHORT, {48'd0, short_addr});
      write_reg(CSR_OWN_LONG, ext_addr);
   endtask

   task automatic run_random_phase();
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) offer_random_frame();
      wait_idle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Radio still off from reset: a start is refused, a lone byte finds no frame.
      offer_start(FTYPE_DATA, 1'b0, 1'b1, 16'h1234, 16'h5678, 64'h0, 8'd3);
      offer_data(8'h33);
      wait_idle();

      // All-ones addresses so that the source fields hit their top values.
      set_config(1'b1, 16'hffff, 16'hffff, '1);
      offer_start(FTYPE_BEACON, 1'b1, 1'b1, 16'h0000, 16'h0000, '1, 8'd0);
      // Short frame, PAN ids differ: source PAN is sent.
      offer_start(FTYPE_DATA, 1'b0, 1'b0, 16'h0000, 16'h0000, 64'h0, 8'd2);
      offer_data(8'h00);
      offer_data(8'hff);
      offer_data(8'h77);
      // Matching PAN ids: compression bit set, source PAN dropped.
      offer_start(FTYPE_ACK, 1'b0, 1'b1, 16'hffff, 16'hffff, 64'h0, 8'd1);
      // Invalid type abandons the open frame.
      offer_start(FTYPE_INVALID, 1'b0, 1'b0, 16'h0000, 16'h0000, 64'h0, 8'd0);
      offer_data(8'h11);
      // Length byte exactly at the limit, then one past it, for each addressing form.
      offer_start(FTYPE_DATA, 1'b1, 1'b0, 16'h0000, 16'h0000, 64'h0123456789abcdef, 8'd106);
      offer_data(8'h5a);
      offer_start(FTYPE_DATA, 1'b1, 1'b1, 16'h0000, 16'h0000, 64'h0, 8'd107);
      offer_start(FTYPE_DATA, 1'b0, 1'b0, 16'hffff, 16'h00ff, 64'h0, 8'd116);
      offer_start(FTYPE_DATA, 1'b0, 1'b0, 16'hffff, 16'h00ff, 64'h0, 8'd117);
      offer_start(FTYPE_BEACON, 1'b0, 1'b1, 16'h8000, 16'hff00, 64'h0, 8'd114);
      offer_start(FTYPE_BEACON, 1'b0, 1'b1, 16'h8000, 16'hff00, 64'h0, 8'd115);
      offer_start(FTYPE_ACK, 1'b0, 1'b0, 16'h0001, 16'h0001, 64'h0, 8'd255);
      // A long-address frame that its one payload byte fills.
      offer_start(FTYPE_DATA, 1'b1, 1'b0, 16'h0000, 16'h0000, 64'h0, 8'd1);
      offer_data(8'ha5);
      wait_idle();

      // Open a frame, switch the radio off, and push the rest of it.
      offer_start(FTYPE_DATA, 1'b0, 1'b0, 16'h4321, 16'h8765, 64'h0, 8'd2);
      offer_data(8'h01);
      wait_idle();
      write_reg(CSR_RADIO_ON, 64'd0);
      offer_data(8'h80);
      offer_start(FTYPE_DATA, 1'b0, 1'b0, 16'h4321, 16'h8765, 64'h0, 8'd2);
      offer_data(8'h02);
      wait_idle();

      // Slow receiver; open with a long hold-off so the block backs up into its input.
      set_config(1'b1, 16'($urandom), 16'($urandom), {$urandom, $urandom});
      holdoff_asked++;
      run_random_phase();

      // Slow sender, all-zero addresses.
      send_idle_pct = 87;
      recv_idle_pct = 16;
      set_config(1'b1, 16'h0000, 16'h0000, 64'h0);
      run_random_phase();

      // Full speed on both sides.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_config(1'b1, 16'($urandom), 16'($urandom), {$urandom, $urandom});
      run_random_phase();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && frame_rsp_q.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/mfhb_pkg.sv
hdl/mfhb_if.sv
hdl/mfhb_hdr_shifter.sv
hdl/mac_frame_header_builder_unit.sv
dv/tb.sv
